[hdl/plir_pkg.sv]
// Shared types, widths and helpers for the pencil layout index remap block.
// No dependencies; every other file of the block imports this package.
package plir_pkg;

    localparam int IW    = 24;   // cell index width
    localparam int CW    = 26;   // width of derived constants and divisors
    localparam int TW    = 25;   // total cell count register width
    localparam int RW    = 13;   // width of the small count registers
    localparam int AW    = 5;    // configuration address width
    localparam int LANES = 5;    // parallel quotient lanes in the cell chain
    localparam int SUMW  = 29;   // width of the final index sum

    typedef logic [CW-1:0] cval_t;

    typedef enum logic [2:0] {
        MODE_Z_TO   = 3'd0,
        MODE_Z_BACK = 3'd1,
        MODE_X_TO   = 3'd2,
        MODE_X_BACK = 3'd3,
        MODE_Y_TO   = 3'd4,
        MODE_Y_BACK = 3'd5
    } mode_t;

    // Quantities derived from the configuration registers.
    typedef struct packed {
        cval_t cpr;   // cells per rank
        cval_t mpr;   // pencils per rank
        cval_t cps;   // cells per stack
        cval_t c2;    // cells per stack over pencil length
        cval_t kq;    // cells per stack over cells per rank
        cval_t rb;    // ranks over stacked count
        cval_t rpt;   // ranks per tower
        cval_t sc;    // stacked count times cells per rank
        cval_t lm;    // pencil length times pencils per rank
        cval_t lsx;   // pencil length times stacked count
        cval_t lsm;   // lsx times pencils per rank
        cval_t lc2;   // pencil length times c2
        cval_t kc;    // kq times cells per rank
        cval_t rm;    // ranks per tower times pencils per rank
        cval_t lrm;   // pencil length times rm
        cval_t rc;    // ranks per tower times cells per rank
        cval_t rsc;   // rc times stacked count
    } derived_t;

    // Control bundle from the configuration unit to the datapath.
    typedef struct packed {
        logic [2:0]                 mode;
        logic [TW-1:0]              total;
        cval_t                      plen;
        cval_t                      stack;
        derived_t                   d;
        logic [LANES-1:0][CW-1:0]   div;
        logic                       stat_bad;
    } plir_ctl_t;

    // One item as it moves along the divider chain.
    typedef struct packed {
        logic [IW-1:0]              idx;
        logic [LANES-1:0][CW-1:0]   rem;
        logic [LANES-1:0][IW-1:0]   quo;
        logic                       bad;
    } plir_stage_t;

    // Product that clamps to all ones once it no longer fits.
    function automatic cval_t sat_mul(input cval_t a, input cval_t b);
        logic [2*CW-1:0] p;
        begin
            p = a * b;
            sat_mul = (|p[2*CW-1:CW]) ? '1 : p[CW-1:0];
        end
    endfunction

endpackage

[hdl/plir_cell.sv]
// One cell of the divider chain: resolves one quotient bit in every lane.
// Depends on plir_pkg.
module plir_cell
    import plir_pkg::*;
#(
    parameter int BIT = 0,
    parameter int VW  = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  plir_stage_t              in_st,
    input  logic [VW-1:0]            in_val,
    input  logic [LANES-1:0][CW-1:0] div,
    output logic                     out_valid,
    output plir_stage_t              out_st,
    output logic [VW-1:0]            out_val
);

    logic        valid_reg;
    plir_stage_t st_reg;
    plir_stage_t st_next;
    logic [VW-1:0] val_reg;

    always_comb
    begin
        logic [CW:0] sh;
        logic [CW:0] diff;
        logic        ge;
        st_next = in_st;
        for (int k = 0; k < LANES; k++)
        begin
            sh   = {in_st.rem[k], in_st.idx[IW-1-BIT]};
            diff = sh - {1'b0, div[k]};
            ge   = (sh >= {1'b0, div[k]});
            st_next.rem[k] = ge ? diff[CW-1:0] : sh[CW-1:0];
            st_next.quo[k] = {in_st.quo[k][IW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg  <= st_next;
            val_reg <= in_val;
        end
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;
    assign out_val   = val_reg;

endmodule

[hdl/plir_cfg.sv]
// Configuration registers and the sequencer that derives the divisors and
// scale factors from them with one shared divider and multiplier. Uses plir_pkg.
module plir_cfg
    import plir_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [AW-1:0] paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          busy,
    output plir_ctl_t     ctl
);

    typedef enum logic [2:0] {
        RG_MODE  = 3'd0,
        RG_TOTAL = 3'd1,
        RG_RANKS = 3'd2,
        RG_PLEN  = 3'd3,
        RG_STACK = 3'd4,
        RG_GX    = 3'd5
    } reg_idx_t;

    typedef enum logic [4:0] {
        OP_CPR, OP_MPR, OP_CPS, OP_C2, OP_KQ, OP_RB, OP_RPT,
        OP_SC, OP_LM, OP_LSX, OP_LSM, OP_LC2, OP_KC, OP_RM, OP_LRM, OP_RC, OP_RSC
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_DIV  = 3'b100
    } state_t;

    logic [2:0]    mode_reg;
    logic [TW-1:0] total_reg;
    logic [RW-1:0] ranks_reg, plen_reg, stack_reg, gx_reg;

    state_t   state_reg, state_next;
    op_t      op_reg, op_next;
    derived_t der_reg;
    cval_t    rem_reg, rem_next, quo_reg, quo_next, den_reg;
    logic [4:0] cnt_reg;

    logic  wr;
    cval_t opa, opb, wr_val;
    logic  is_div, wr_en, div_done;
    logic [CW:0] sh, diff;

    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 3'd0;
            total_reg <= TW'(1);
            ranks_reg <= RW'(1);
            plen_reg  <= RW'(1);
            stack_reg <= RW'(1);
            gx_reg    <= RW'(1);
        end
        else if (wr)
        begin
            case (paddr[AW-1:2])
                RG_MODE:  mode_reg  <= pwdata[2:0];
                RG_TOTAL: total_reg <= pwdata[TW-1:0];
                RG_RANKS: ranks_reg <= pwdata[RW-1:0];
                RG_PLEN:  plen_reg  <= pwdata[RW-1:0];
                RG_STACK: stack_reg <= pwdata[RW-1:0];
                RG_GX:    gx_reg    <= pwdata[RW-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[AW-1:2])
            RG_MODE:  prdata = 32'(mode_reg);
            RG_TOTAL: prdata = 32'(total_reg);
            RG_RANKS: prdata = 32'(ranks_reg);
            RG_PLEN:  prdata = 32'(plen_reg);
            RG_STACK: prdata = 32'(stack_reg);
            RG_GX:    prdata = 32'(gx_reg);
            default:  prdata = 32'd0;
        endcase
    end

    // Operands of each derivation step.
    always_comb
    begin
        case (op_reg)
            OP_CPR:  begin opa = CW'(total_reg);  opb = CW'(ranks_reg); end
            OP_MPR:  begin opa = der_reg.cpr;     opb = CW'(plen_reg);  end
            OP_CPS:  begin opa = CW'(total_reg);  opb = CW'(stack_reg); end
            OP_C2:   begin opa = der_reg.cps;     opb = CW'(plen_reg);  end
            OP_KQ:   begin opa = der_reg.cps;     opb = der_reg.cpr;    end
            OP_RB:   begin opa = CW'(ranks_reg);  opb = CW'(stack_reg); end
            OP_RPT:  begin opa = der_reg.rb;      opb = CW'(gx_reg);    end
            OP_SC:   begin opa = CW'(stack_reg);  opb = der_reg.cpr;    end
            OP_LM:   begin opa = CW'(plen_reg);   opb = der_reg.mpr;    end
            OP_LSX:  begin opa = CW'(plen_reg);   opb = CW'(stack_reg); end
            OP_LSM:  begin opa = der_reg.lsx;     opb = der_reg.mpr;    end
            OP_LC2:  begin opa = CW'(plen_reg);   opb = der_reg.c2;     end
            OP_KC:   begin opa = der_reg.kq;      opb = der_reg.cpr;    end
            OP_RM:   begin opa = der_reg.rpt;     opb = der_reg.mpr;    end
            OP_LRM:  begin opa = CW'(plen_reg);   opb = der_reg.rm;     end
            OP_RC:   begin opa = der_reg.rpt;     opb = der_reg.cpr;    end
            OP_RSC:  begin opa = der_reg.rc;      opb = CW'(stack_reg); end
            default: begin opa = '0;              opb = '0;             end
        endcase
    end

    assign is_div   = (op_reg <= OP_RPT);
    assign sh       = {rem_reg, quo_reg[CW-1]};
    assign diff     = sh - {1'b0, den_reg};
    assign rem_next = (sh >= {1'b0, den_reg}) ? diff[CW-1:0] : sh[CW-1:0];
    assign quo_next = {quo_reg[CW-2:0], (sh >= {1'b0, den_reg})};
    assign div_done = (state_reg == ST_DIV) && (cnt_reg == 5'(CW-1));
    assign wr_en    = ((state_reg == ST_LOAD) && !is_div) || div_done;
    assign wr_val   = (state_reg == ST_LOAD) ? sat_mul(opa, opb)
                    : ((den_reg == '0) ? '0 : quo_next);
    assign op_next  = op_t'(op_reg + 5'd1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: state_next = ST_IDLE;
            ST_LOAD:
            begin
                if (is_div)
                    state_next = ST_DIV;
                else if (op_reg == OP_RSC)
                    state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_LOAD;
            end
            default: state_next = ST_IDLE;
        endcase
        if (wr)
            state_next = ST_LOAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            op_reg    <= OP_CPR;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr)
                op_reg <= OP_CPR;
            else if (wr_en && (op_reg != OP_RSC))
                op_reg <= op_next;
            if (state_reg == ST_DIV)
                cnt_reg <= cnt_reg + 5'd1;
            else
                cnt_reg <= 5'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            rem_reg <= '0;
            quo_reg <= opa;
            den_reg <= opb;
        end
        else
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (wr_en)
        begin
            case (op_reg)
                OP_CPR:  der_reg.cpr <= wr_val;
                OP_MPR:  der_reg.mpr <= wr_val;
                OP_CPS:  der_reg.cps <= wr_val;
                OP_C2:   der_reg.c2  <= wr_val;
                OP_KQ:   der_reg.kq  <= wr_val;
                OP_RB:   der_reg.rb  <= wr_val;
                OP_RPT:  der_reg.rpt <= wr_val;
                OP_SC:   der_reg.sc  <= wr_val;
                OP_LM:   der_reg.lm  <= wr_val;
                OP_LSX:  der_reg.lsx <= wr_val;
                OP_LSM:  der_reg.lsm <= wr_val;
                OP_LC2:  der_reg.lc2 <= wr_val;
                OP_KC:   der_reg.kc  <= wr_val;
                OP_RM:   der_reg.rm  <= wr_val;
                OP_LRM:  der_reg.lrm <= wr_val;
                OP_RC:   der_reg.rc  <= wr_val;
                OP_RSC:  der_reg.rsc <= wr_val;
                default: ;
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);

    // Lane divisors and the error conditions that follow from the setup alone.
    always_comb
    begin
        logic zero_base;
        logic one_div;
        ctl.mode     = mode_reg;
        ctl.total    = total_reg;
        ctl.plen     = CW'(plen_reg);
        ctl.stack    = CW'(stack_reg);
        ctl.d        = der_reg;
        one_div      = 1'b1;
        zero_base    = (ranks_reg == '0) || (plen_reg == '0) || (stack_reg == '0);
        ctl.div[0]   = CW'(plen_reg);
        ctl.div[1]   = CW'(one_div);
        ctl.div[2]   = CW'(one_div);
        ctl.div[3]   = CW'(one_div);
        ctl.div[4]   = CW'(one_div);
        ctl.stat_bad = 1'b1;
        case (mode_reg)
            MODE_Z_TO:
            begin
                ctl.div[1] = der_reg.cpr;
                ctl.div[2] = der_reg.lm;
                ctl.div[3] = der_reg.sc;
                ctl.stat_bad = zero_base || (der_reg.mpr == '0);
            end
            MODE_Z_BACK:
            begin
                ctl.div[1] = der_reg.sc;
                ctl.div[2] = der_reg.lsx;
                ctl.div[3] = der_reg.lsm;
                ctl.stat_bad = zero_base || (der_reg.mpr == '0);
            end
            MODE_X_TO:
            begin
                ctl.div[1] = der_reg.lc2;
                ctl.div[2] = der_reg.cps;
                ctl.stat_bad = zero_base || (der_reg.c2 == '0);
            end
            MODE_X_BACK:
            begin
                ctl.div[1] = der_reg.lsx;
                ctl.div[2] = der_reg.sc;
                ctl.div[3] = der_reg.lsm;
                ctl.stat_bad = zero_base || (der_reg.mpr == '0);
            end
            MODE_Y_TO:
            begin
                ctl.div[1] = der_reg.lrm;
                ctl.div[2] = der_reg.rsc;
                ctl.div[3] = der_reg.rc;
                ctl.stat_bad = zero_base || (der_reg.mpr == '0) || (gx_reg == '0)
                            || (der_reg.rpt == '0);
            end
            MODE_Y_BACK:
            begin
                ctl.div[1] = der_reg.lsx;
                ctl.div[2] = der_reg.sc;
                ctl.div[3] = der_reg.rsc;
                ctl.div[4] = der_reg.lsm;
                ctl.stat_bad = zero_base || (der_reg.mpr == '0) || (gx_reg == '0)
                            || (der_reg.rpt == '0);
            end
            default: ctl.stat_bad = 1'b1;
        endcase
    end

endmodule

[hdl/plir_post.sv]
// Three-stage back end: turns the lane quotients into the destination index
// with remainders, scaled terms and a final sum. Uses plir_pkg.
module plir_post
    import plir_pkg::*;
#(
    parameter int VW   = 32,
    parameter int MAXC = 16777216
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  plir_stage_t   in_st,
    input  logic [VW-1:0] in_val,
    input  plir_ctl_t     ctl,
    output logic          out_valid,
    output logic [IW-1:0] out_target,
    output logic [VW-1:0] out_val,
    output logic          out_err
);

    logic                       s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [IW-1:0]              s1_idx_reg;
    logic [LANES-1:0][IW-1:0]   s1_q_reg, s2_q_reg;
    logic                       s1_bad_reg, s2_bad_reg, s3_bad_reg;
    logic [VW-1:0]              s1_val_reg, s2_val_reg, s3_val_reg;
    cval_t                      s1_lop_reg, s2_lo_reg, s3_lo_reg;
    logic [2:0][CW-1:0]         s1_am_reg, s1_ap_reg, s2_a_reg;
    logic [2:0]                 s1_sub_reg;
    logic [3:0][CW-1:0]         s3_p_reg;

    logic [2:0][CW-1:0]         am_next, ap_next, a_next;
    logic [2:0]                 sub_next;
    logic [3:0][CW-1:0]         p_next;
    logic [SUMW-1:0]            sum;

    // Stage one: the remainder products of the selected mode.
    always_comb
    begin
        logic [LANES-1:0][CW-1:0] qx;
        logic [2:0][CW-1:0]       mm, mq;
        for (int k = 0; k < LANES; k++)
            qx[k] = CW'(in_st.quo[k]);
        mm       = '0;
        mq       = '0;
        ap_next  = '0;
        sub_next = '0;
        case (ctl.mode)
            MODE_Z_TO:
            begin
                ap_next[0] = qx[0]; mm[0] = ctl.d.mpr; mq[0] = qx[2]; sub_next[0] = 1'b1;
                ap_next[1] = qx[1]; mm[1] = ctl.stack; mq[1] = qx[3]; sub_next[1] = 1'b1;
            end
            MODE_Z_BACK:
            begin
                ap_next[0] = qx[0]; mm[0] = ctl.stack; mq[0] = qx[2]; sub_next[0] = 1'b1;
                ap_next[1] = qx[2]; mm[1] = ctl.d.mpr; mq[1] = qx[3]; sub_next[1] = 1'b1;
            end
            MODE_X_TO:
            begin
                ap_next[0] = qx[0]; mm[0] = ctl.d.c2;  mq[0] = qx[1]; sub_next[0] = 1'b1;
            end
            MODE_X_BACK:
            begin
                ap_next[0] = qx[0]; mm[0] = ctl.stack; mq[0] = qx[1]; sub_next[0] = 1'b1;
                ap_next[1] = qx[1]; mm[1] = ctl.d.mpr; mq[1] = qx[3]; sub_next[1] = 1'b1;
            end
            MODE_Y_TO:
            begin
                ap_next[0] = qx[0]; mm[0] = ctl.d.rm;  mq[0] = qx[1]; sub_next[0] = 1'b1;
                ap_next[1] = qx[3]; mm[1] = ctl.stack; mq[1] = qx[2]; sub_next[1] = 1'b1;
            end
            MODE_Y_BACK:
            begin
                ap_next[0] = qx[0]; mm[0] = ctl.stack; mq[0] = qx[1]; sub_next[0] = 1'b1;
                ap_next[1] = qx[1]; mm[1] = ctl.d.mpr; mq[1] = qx[4]; sub_next[1] = 1'b1;
                mm[2] = ctl.d.rpt; mq[2] = qx[3];
            end
            default: ;
        endcase
        for (int k = 0; k < 3; k++)
            am_next[k] = sat_mul(mm[k], mq[k]);
    end

    // Stage two: finish the remainders.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            a_next[k] = s1_sub_reg[k] ? (s1_ap_reg[k] - s1_am_reg[k]) : s1_am_reg[k];
    end

    // Stage three: the scaled terms of the index.
    always_comb
    begin
        logic [3:0][CW-1:0]       xb, yb;
        logic [LANES-1:0][CW-1:0] qx;
        for (int k = 0; k < LANES; k++)
            qx[k] = CW'(s2_q_reg[k]);
        xb = '0;
        yb = '0;
        case (ctl.mode)
            MODE_Z_TO:
            begin
                xb[0] = qx[3];       yb[0] = ctl.d.sc;
                xb[1] = s2_a_reg[1]; yb[1] = ctl.plen;
                xb[2] = s2_a_reg[0]; yb[2] = ctl.d.lsx;
            end
            MODE_Z_BACK:
            begin
                xb[0] = qx[1];       yb[0] = ctl.d.sc;
                xb[1] = s2_a_reg[0]; yb[1] = ctl.d.cpr;
                xb[2] = s2_a_reg[1]; yb[2] = ctl.plen;
            end
            MODE_X_TO:
            begin
                xb[0] = qx[2];       yb[0] = ctl.plen;
                xb[1] = s2_a_reg[0]; yb[1] = ctl.d.lsx;
            end
            MODE_X_BACK:
            begin
                xb[0] = qx[2];       yb[0] = ctl.d.cpr;
                xb[1] = s2_a_reg[0]; yb[1] = ctl.d.kc;
                xb[2] = s2_a_reg[1]; yb[2] = ctl.plen;
            end
            MODE_Y_TO:
            begin
                xb[0] = s2_a_reg[0]; yb[0] = ctl.d.lsx;
                xb[1] = s2_a_reg[1]; yb[1] = ctl.plen;
                xb[2] = qx[2];       yb[2] = ctl.d.rsc;
            end
            MODE_Y_BACK:
            begin
                xb[0] = s2_a_reg[0]; yb[0] = ctl.d.rc;
                xb[1] = qx[2];       yb[1] = ctl.d.cpr;
                xb[2] = s2_a_reg[2]; yb[2] = ctl.d.cpr;
                xb[3] = s2_a_reg[1]; yb[3] = ctl.plen;
            end
            default: ;
        endcase
        for (int j = 0; j < 4; j++)
            p_next[j] = sat_mul(xb[j], yb[j]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_idx_reg <= in_st.idx;
            s1_q_reg   <= in_st.quo;
            s1_bad_reg <= in_st.bad;
            s1_val_reg <= in_val;
            s1_lop_reg <= sat_mul(ctl.plen, CW'(in_st.quo[0]));
            s1_am_reg  <= am_next;
            s1_ap_reg  <= ap_next;
            s1_sub_reg <= sub_next;

            s2_q_reg   <= s1_q_reg;
            s2_bad_reg <= s1_bad_reg;
            s2_val_reg <= s1_val_reg;
            s2_lo_reg  <= CW'(s1_idx_reg) - s1_lop_reg;
            s2_a_reg   <= a_next;

            s3_bad_reg <= s2_bad_reg;
            s3_val_reg <= s2_val_reg;
            s3_lo_reg  <= s2_lo_reg;
            s3_p_reg   <= p_next;
        end
    end

    // Any clamped term already exceeds every legal cell count.
    assign sum = SUMW'(s3_lo_reg) + SUMW'(s3_p_reg[0]) + SUMW'(s3_p_reg[1])
               + SUMW'(s3_p_reg[2]) + SUMW'(s3_p_reg[3]);

    assign out_err    = s3_bad_reg || ctl.stat_bad || (sum >= SUMW'(ctl.total))
                     || (32'(sum) >= 32'(MAXC));
    assign out_target = out_err ? '0 : sum[IW-1:0];
    assign out_valid  = s3_valid_reg;
    assign out_val    = s3_val_reg;

endmodule

[hdl/pencil_layout_index_remap.sv]
// Top level of the pencil layout index remap block: stream ports, the
// divider cell chain, the back end and the output register.
// Depends on plir_pkg, plir_cfg, plir_cell and plir_post.
//
// Usage:
// Each word on the slave stream carries one grid cell (its source index and
// data word). The master stream returns one word per cell, in order, with
// the destination index for the selected reorder mode, the data word
// unchanged and an error flag in tuser. A flagged word always has index zero.
// The index is resolved by a chain of 24 cells, one quotient bit per cell
// in five parallel lanes, followed by three arithmetic stages and the output
// register, which a cell passes through in turn before it appears on the master side.
// One word is accepted per cycle while s_tready is high.
// Registers are written through the APB port. Every write, and the release
// of reset, starts a derivation pass in the configuration unit (seven
// divisions and ten products, one after another) during which s_tready is low.
// Reset loads mode 0 and all counts 1.
// When the receiver stalls, the output register holds its word and the
// chain keeps moving until a finished word reaches its last stage; only
// then does the whole chain, and s_tready, stop.
module pencil_layout_index_remap
    import plir_pkg::*;
#(
    parameter int MAX_CELLS  = 16777216,
    parameter int VALUE_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Slave stream, tdata from bit 0: cell_index, cell_value, zero fill.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [((IW+VALUE_BITS+7)/8)*8-1:0] s_tdata,
    // Master stream, tdata from bit 0: target_index, moved_value, zero fill.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [((IW+VALUE_BITS+7)/8)*8-1:0] m_tdata,
    // tuser holds layout_error.
    output logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [AW-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DW = ((IW + VALUE_BITS + 7) / 8) * 8;
    // Only the low 32 bits of the data word pass through.
    localparam logic [VALUE_BITS-1:0] VMASK = VALUE_BITS'(32'hFFFF_FFFF);

    plir_ctl_t ctl;
    logic      cfg_busy;
    logic      adv;
    logic      accept;

    plir_stage_t             ch_st  [IW+1];
    logic [VALUE_BITS-1:0]   ch_val [IW+1];
    logic                    ch_v   [IW+1];

    logic                  post_valid;
    logic [IW-1:0]         post_target;
    logic [VALUE_BITS-1:0] post_val;
    logic                  post_err;

    logic                  out_valid_reg, out_valid_next;
    logic [IW-1:0]         out_target_reg;
    logic [VALUE_BITS-1:0] out_val_reg;
    logic                  out_err_reg;
    logic                  load;

    plir_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .busy    (cfg_busy),
        .ctl     (ctl)
    );

    assign pready = 1'b1;

    // The chain only stops when a finished word cannot enter the output register.
    assign adv      = !(post_valid && out_valid_reg && !m_tready);
    assign s_tready = adv && !cfg_busy;
    assign accept   = s_tvalid && s_tready;

    assign ch_v[0]       = accept;
    assign ch_val[0]     = s_tdata[IW +: VALUE_BITS] & VMASK;
    assign ch_st[0].idx  = s_tdata[IW-1:0];
    assign ch_st[0].rem  = '0;
    assign ch_st[0].quo  = '0;
    assign ch_st[0].bad  = ({1'b0, s_tdata[IW-1:0]} >= ctl.total);

    for (genvar g = 0; g < IW; g++)
    begin : g_cell
        plir_cell #(
            .BIT (g),
            .VW  (VALUE_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (ch_v[g]),
            .in_st     (ch_st[g]),
            .in_val    (ch_val[g]),
            .div       (ctl.div),
            .out_valid (ch_v[g+1]),
            .out_st    (ch_st[g+1]),
            .out_val   (ch_val[g+1])
        );
    end

    plir_post #(
        .VW   (VALUE_BITS),
        .MAXC (MAX_CELLS)
    ) u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (ch_v[IW]),
        .in_st      (ch_st[IW]),
        .in_val     (ch_val[IW]),
        .ctl        (ctl),
        .out_valid  (post_valid),
        .out_target (post_target),
        .out_val    (post_val),
        .out_err    (post_err)
    );

    assign load           = post_valid && adv;
    assign out_valid_next = load || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_target_reg <= post_target;
            out_val_reg    <= post_val;
            out_err_reg    <= post_err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DW'({out_val_reg, out_target_reg});
    assign m_tuser  = out_err_reg;

    // A flagged word never carries an index.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[IW-1:0] == '0))
        else $error("flagged word with nonzero index");

    // A register write always starts a derivation pass that blocks input.
    a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite |=> !s_tready)
        else $error("input accepted right after a register write");

    // No word is taken while a finished word is stuck behind the output.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        post_valid && out_valid_reg && !m_tready |-> !s_tready)
        else $error("input accepted while the chain is stalled");

endmodule
